// File: hdl/dfs_pkg.sv
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int MAX_RECORD_BYTES = 65536;
    localparam int MAX_FIELDS       = 256;

    localparam int POS_W     = 16;
    localparam int COUNT_W   = 9;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int POS_CAP_INT   = (MAX_RECORD_BYTES - 1 > 65535) ? 65535
                                                                  : MAX_RECORD_BYTES - 1;
    localparam int FIELD_CAP_INT = (MAX_FIELDS > 511) ? 511 : MAX_FIELDS;

    localparam logic [POS_W-1:0]   POS_CAP   = POS_W'(POS_CAP_INT);
    localparam logic [COUNT_W-1:0] FIELD_CAP = COUNT_W'(FIELD_CAP_INT);

    localparam logic [POS_W-1:0] LEN_MAX = {POS_W{1'b1}};

    localparam logic [BYTE_W-1:0]  DELIM_FIRST_RST  = 8'd44;
    localparam logic [BYTE_W-1:0]  DELIM_SECOND_RST = 8'd10;
    localparam logic [COUNT_W-1:0] MAX_FIELDS_RST   = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_MODE    = 2'd0,
        CFG_DELIM_FIRST  = 2'd1,
        CFG_DELIM_SECOND = 2'd2,
        CFG_MAX_FIELDS   = 2'd3
    } cfg_index_t;

    // saturating position increment
    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        begin
            if (p >= POS_CAP)
            begin
                r = POS_CAP;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    // clamped distance between two positions
    function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] from_pos,
                                              input logic [POS_W:0]   to_pos);
        logic [POS_W:0]   diff;
        logic [POS_W-1:0] r;
        begin
            diff = to_pos - {1'b0, from_pos};
            if (to_pos <= {1'b0, from_pos})
            begin
                r = '0;
            end
            else if (diff[POS_W])
            begin
                r = LEN_MAX;
            end
            else
            begin
                r = diff[POS_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// File: hdl/delimited_field_splitter_unit.sv
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// in       input      in_valid/in_stall  data_byte, last_byte
// out      output     out_valid/out_stall field_valid, field_offset, field_length,
//                                        record_end, field_count
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word per cycle sustained while the output is not stalled; a word passes an input
// register, then the compare and counter logic writes the result register
// the result register is the only thing that blocks the input side: a word
// moves on whenever the result register is empty or being taken
// rst_n clears the record state, the handshake flags and the registers to
// their default delimiter ',' / newline and a field limit of 256
// cfg_ready is always high

module delimited_field_splitter_unit (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dfs_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           last_byte,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           field_valid,
    output logic [dfs_pkg::POS_W-1:0]      field_offset,
    output logic [dfs_pkg::POS_W-1:0]      field_length,
    output logic                           record_end,
    output logic [dfs_pkg::COUNT_W-1:0]    field_count,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    import dfs_pkg::*;

    logic                 pair_mode_reg;
    logic [BYTE_W-1:0]    delim_first_reg;
    logic [BYTE_W-1:0]    delim_second_reg;
    logic [COUNT_W-1:0]   max_fields_reg;

    logic                 in_full_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;

    logic [POS_W-1:0]     byte_pos_reg,    byte_pos_next;
    logic [POS_W-1:0]     field_start_reg, field_start_next;
    logic [COUNT_W-1:0]   fields_done_reg, fields_done_next;
    logic                 pending_reg,     pending_next;

    logic                 out_valid_reg,   out_valid_next;
    logic                 fvalid_reg,      fvalid_next;
    logic [POS_W-1:0]     offset_reg,      offset_next;
    logic [POS_W-1:0]     length_reg,      length_next;
    logic                 rec_end_reg,     rec_end_next;
    logic [COUNT_W-1:0]   count_reg,       count_next;

    logic                 out_free;
    logic                 advance;
    logic                 in_take;
    logic                 closed;
    logic                 under_limit;
    logic [COUNT_W-1:0]   limit;
    logic [POS_W-1:0]     close_end;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_full_reg && out_free;
    assign in_stall  = in_full_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign field_valid  = fvalid_reg;
    assign field_offset = offset_reg;
    assign field_length = length_reg;
    assign record_end   = rec_end_reg;
    assign field_count  = count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_mode_reg    <= 1'b0;
            delim_first_reg  <= DELIM_FIRST_RST;
            delim_second_reg <= DELIM_SECOND_RST;
            max_fields_reg   <= MAX_FIELDS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PAIR_MODE:    pair_mode_reg    <= cfg_data[0];
                CFG_DELIM_FIRST:  delim_first_reg  <= cfg_data[BYTE_W-1:0];
                CFG_DELIM_SECOND: delim_second_reg <= cfg_data[BYTE_W-1:0];
                CFG_MAX_FIELDS:   max_fields_reg   <= cfg_data[COUNT_W-1:0];
                default:          pair_mode_reg    <= pair_mode_reg;
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // field scan
    always_comb
    begin
        limit       = (max_fields_reg < FIELD_CAP) ? max_fields_reg : FIELD_CAP;
        under_limit = fields_done_reg < limit;
        closed      = 1'b0;
        close_end   = byte_pos_reg;
        pending_next = 1'b0;

        if (pair_mode_reg)
        begin
            closed    = pending_reg && (in_byte_reg == delim_second_reg);
            close_end = (byte_pos_reg != '0) ? byte_pos_reg - 1'b1 : '0;
            pending_next = !closed && (in_byte_reg == delim_first_reg) && !in_last_reg;
        end
        else
        begin
            closed    = in_byte_reg == delim_first_reg;
            close_end = byte_pos_reg;
        end

        fvalid_next  = (closed || in_last_reg) && under_limit;
        offset_next  = '0;
        length_next  = '0;
        if (fvalid_next)
        begin
            offset_next = field_start_reg;
            if (closed)
            begin
                length_next = span(field_start_reg, {1'b0, close_end});
            end
            else
            begin
                length_next = span(field_start_reg, {1'b0, byte_pos_reg} + 1'b1);
            end
        end

        count_next     = fields_done_reg + COUNT_W'(fvalid_next);
        rec_end_next   = in_last_reg;
        out_valid_next = in_last_reg || fvalid_next;

        if (in_last_reg)
        begin
            byte_pos_next    = '0;
            field_start_next = '0;
            fields_done_next = '0;
            pending_next     = 1'b0;
        end
        else
        begin
            byte_pos_next    = sat_inc(byte_pos_reg);
            field_start_next = closed ? sat_inc(byte_pos_reg) : field_start_reg;
            fields_done_next = count_next;
        end
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg    <= '0;
            field_start_reg <= '0;
            fields_done_reg <= '0;
            pending_reg     <= 1'b0;
        end
        else if (advance)
        begin
            byte_pos_reg    <= byte_pos_next;
            field_start_reg <= field_start_next;
            fields_done_reg <= fields_done_next;
            pending_reg     <= pending_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && out_free)
        begin
            fvalid_reg  <= fvalid_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            rec_end_reg <= rec_end_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: test/delimited_field_splitter_unit_tb.sv
`timescale 1ns / 1ps

module delimited_field_splitter_unit_tb;

    import dfs_pkg::*;

    localparam int POS_TOP = (MAX_RECORD_BYTES - 1 > 65535) ? 65535 : MAX_RECORD_BYTES - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              ends;
    } rec_byte_t;

    typedef struct packed {
        logic               has_field;
        logic [POS_W-1:0]   offset;
        logic [POS_W-1:0]   length;
        logic               closes;
        logic [COUNT_W-1:0] count;
    } field_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 last_byte = 1'b0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 field_valid;
    logic [POS_W-1:0]     field_offset;
    logic [POS_W-1:0]     field_length;
    logic                 record_end;
    logic [COUNT_W-1:0]   field_count;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PAIR_MODE;
    logic [31:0]          cfg_data = '0;

    // splitter settings as last written
    logic                 mode_pair = 1'b0;
    logic [BYTE_W-1:0]    delim_a = DELIM_FIRST_RST;
    logic [BYTE_W-1:0]    delim_b = DELIM_SECOND_RST;
    logic [COUNT_W-1:0]   field_limit_reg = MAX_FIELDS_RST;

    // record state of the expected splitter
    logic [POS_W-1:0]     at_pos = '0;
    logic [POS_W-1:0]     open_start = '0;
    int                   fields_out = 0;
    logic                 held_first = 1'b0;

    rec_byte_t            bytes_to_send[$];
    field_result_t        fields_due[$];
    int                   sent_total = 0;
    int                   taken_total = 0;
    int                   mismatches = 0;

    logic                 idle_on = 1'b0;
    int                   hold_ticket = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   stall_left = 0;
    int                   gap_left = 0;
    int                   quiet = 0;

    delimited_field_splitter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_valid  (field_valid),
        .field_offset (field_offset),
        .field_length (field_length),
        .record_end   (record_end),
        .field_count  (field_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [POS_W-1:0] bump_pos(input logic [POS_W-1:0] p);
        return (p >= POS_TOP) ? POS_W'(POS_TOP) : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] clamp_len(input logic [POS_W-1:0] from_pos,
                                                   input logic [POS_W:0]   to_pos);
        logic [POS_W:0] d;
        if (to_pos <= {1'b0, from_pos})
        begin
            return '0;
        end
        d = to_pos - {1'b0, from_pos};
        return d[POS_W] ? {POS_W{1'b1}} : d[POS_W-1:0];
    endfunction

    function automatic void split_byte(input logic [BYTE_W-1:0] b, input logic ends);
        int               lim;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] stop;
        logic [POS_W-1:0] resume;
        logic             closed;
        field_result_t    r;
        lim = (int'(field_limit_reg) < MAX_FIELDS) ? int'(field_limit_reg) : MAX_FIELDS;
        pos = at_pos;
        stop = '0;
        resume = '0;
        closed = 1'b0;
        r = '0;
        if (mode_pair)
        begin
            if (held_first && b == delim_b)
            begin
                closed = 1'b1;
                stop = (pos > 0) ? pos - 1'b1 : '0;
                resume = bump_pos(pos);
                held_first = 1'b0;
            end
            else
            begin
                held_first = (b == delim_a) && !ends;
            end
        end
        else
        begin
            held_first = 1'b0;
            if (b == delim_a)
            begin
                closed = 1'b1;
                stop = pos;
                resume = bump_pos(pos);
            end
        end
        if (closed)
        begin
            if (fields_out < lim)
            begin
                r.has_field = 1'b1;
                r.offset = open_start;
                r.length = clamp_len(open_start, {1'b0, stop});
                fields_out++;
            end
            open_start = resume;
        end
        else if (ends && fields_out < lim)
        begin
            r.has_field = 1'b1;
            r.offset = open_start;
            r.length = clamp_len(open_start, {1'b0, pos} + 1'b1);
            fields_out++;
        end
        r.closes = ends;
        r.count = fields_out[COUNT_W-1:0];
        if (ends || r.has_field)
        begin
            fields_due = {fields_due, r};
        end
        if (ends)
        begin
            at_pos = '0;
            open_start = '0;
            fields_out = 0;
            held_first = 1'b0;
        end
        else
        begin
            at_pos = bump_pos(pos);
        end
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < 100)
        begin
            $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        end
        mismatches++;
    endtask

    // driver
    always @(posedge clk)
    begin
        rec_byte_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                split_byte(data_byte, last_byte);
                taken_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 14);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (bytes_to_send.size() > 0)
                begin
                    w = bytes_to_send.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= w.value;
                    last_byte <= w.ends;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (fields_due.size() == 0)
                begin
                    note_mismatch("word with nothing expected, offset", field_offset, 0);
                end
                else
                begin
                    want = fields_due.pop_front();
                    if (field_valid !== want.has_field)
                        note_mismatch("field_valid", field_valid, want.has_field);
                    if (field_offset !== want.offset)
                        note_mismatch("field_offset", field_offset, want.offset);
                    if (field_length !== want.length)
                        note_mismatch("field_length", field_length, want.length);
                    if (record_end !== want.closes)
                        note_mismatch("record_end", record_end, want.closes);
                    if (field_count !== want.count)
                        note_mismatch("field_count", field_count, want.count);
                end
            end
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("delimited_field_splitter_unit regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAIR_MODE:    mode_pair = val[0];
            CFG_DELIM_FIRST:  delim_a = val[BYTE_W-1:0];
            CFG_DELIM_SECOND: delim_b = val[BYTE_W-1:0];
            CFG_MAX_FIELDS:   field_limit_reg = val[COUNT_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_regs(input logic pair, input logic [BYTE_W-1:0] a,
                            input logic [BYTE_W-1:0] b, input logic [COUNT_W-1:0] lim);
        write_reg(CFG_PAIR_MODE, 32'(pair));
        write_reg(CFG_DELIM_FIRST, 32'(a));
        write_reg(CFG_DELIM_SECOND, 32'(b));
        write_reg(CFG_MAX_FIELDS, 32'(lim));
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic ends);
        rec_byte_t w;
        w.value = b;
        w.ends = ends;
        bytes_to_send = {bytes_to_send, w};
        sent_total++;
    endtask

    task automatic add_text(input string s, input logic close);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            add_byte(s[i], close && i == s.len() - 1);
        end
    endtask

    // mostly random bytes, the rest delimiters and pairs and some lone halves of a pair
    task automatic rand_record(input int n, input logic close);
        int k;
        int pick;
        k = 0;
        while (k < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                add_byte(delim_a, close && k == n - 1);
                k++;
                if (mode_pair && pick < 2 && k < n)
                begin
                    add_byte(delim_b, close && k == n - 1);
                    k++;
                end
            end
            else if (pick == 3)
            begin
                add_byte(delim_b, close && k == n - 1);
                k++;
            end
            else
            begin
                add_byte(BYTE_W'($urandom_range(0, 255)), close && k == n - 1);
                k++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (taken_total != sent_total || fields_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        int len;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [COUNT_W-1:0] lim;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on <= 1'b1;

        add_text("ab,c", 1'b1);
        add_byte(DELIM_FIRST_RST, 1'b0);
        add_byte(DELIM_FIRST_RST, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        add_text("a,", 1'b1);
        add_text(",", 1'b1);
        wait_idle();

        set_regs(1'b0, DELIM_FIRST_RST, DELIM_SECOND_RST, 9'd1);
        add_text("a,b", 1'b1);
        wait_idle();
        set_regs(1'b0, DELIM_FIRST_RST, DELIM_SECOND_RST, 9'd0);
        add_text("q", 1'b1);
        wait_idle();

        set_regs(1'b1, DELIM_FIRST_RST, DELIM_SECOND_RST, 9'd511);
        add_text("a,\nb,c,", 1'b1);
        add_text("x,", 1'b0);
        wait_idle();
        // pending first char dropped when switching to single mode
        set_regs(1'b0, DELIM_FIRST_RST, DELIM_SECOND_RST, 9'd511);
        add_text("\ny", 1'b1);
        wait_idle();
        set_regs(1'b1, "a", "a", 9'd511);
        add_text("aaa", 1'b1);
        wait_idle();

        // field limit above the parameter bound
        set_regs(1'b0, DELIM_FIRST_RST, DELIM_SECOND_RST, 9'd511);
        for (n = 0; n < 300; n++)
        begin
            add_byte(DELIM_FIRST_RST, 1'b0);
        end
        add_text("z", 1'b1);
        wait_idle();

        for (ph = 0; ph < 11; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       a = DELIM_FIRST_RST;
                1:       a = 8'h00;
                2:       a = 8'hFF;
                default: a = BYTE_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       b = a;
                1:       b = DELIM_SECOND_RST;
                2:       b = 8'h00;
                3:       b = 8'hFF;
                default: b = BYTE_W'($urandom_range(0, 255));
            endcase
            if (ph < 2)
            begin
                a = (ph == 0) ? 8'h00 : 8'hFF;
                b = ~a;
            end
            case ($urandom_range(0, 6))
                0:       lim = 9'd0;
                1:       lim = 9'd1;
                2:       lim = COUNT_W'($urandom_range(2, 5));
                3:       lim = 9'd256;
                4:       lim = 9'd511;
                default: lim = COUNT_W'($urandom_range(0, 511));
            endcase
            idle_on <= (ph < 10) && (ph != 3) && (ph != 6);
            set_regs(1'($urandom_range(0, 1)), a, b, lim);
            n = 0;
            while (n < 55)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 20);
                rand_record(len, 1'b1);
                n += len;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                rand_record($urandom_range(1, 6), 1'b0);
            end
            if (ph == 3)
            begin
                @(posedge clk);
                hold_ticket <= hold_ticket + 1;
            end
            wait_idle();
        end

        if (fields_due.size() != 0)
        begin
            note_mismatch("results never seen", fields_due.size(), 0);
        end
        if (mismatches == 0)
        begin
            $display("delimited_field_splitter_unit regression: pass");
        end
        else
        begin
            $display("delimited_field_splitter_unit regression: fail");
        end
        $finish;
    end

endmodule
